// ===== design/kmrb_pkg.sv =====
package kmrb_pkg;

    localparam int TABLE_ENTRIES  = 128;
    localparam int MATRIX_COLUMNS = 8;
    localparam int KEY_CODES      = 256;

    localparam int CMD_W   = 2;
    localparam int CODE_W  = 8;
    localparam int INDEX_W = 7;
    localparam int COL_W   = 3;
    localparam int ROWS_W  = 8;

    // table address and walk counter widths
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [CMD_W-1:0] CMD_KEY_EVENT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_ENTRY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD       = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] code_a;
        logic [CODE_W-1:0] code_b;
        logic [COL_W-1:0]  col_a;
        logic [ROWS_W-1:0] rows_a;
        logic [COL_W-1:0]  col_b;
        logic [ROWS_W-1:0] rows_b;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CODE_W-1:0]  scan_code;
        logic               key_pressed;
        logic [INDEX_W-1:0] entry_index;
        entry_t             entry;
    } in_item_t;

    typedef struct packed {
        logic key_wr;
        logic tbl_wr;
        logic start;
        logic walk_en;
        logic emit_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic emit_last;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== design/kmrb_in_if.sv =====
interface kmrb_in_if;
    logic                            valid;
    logic                            ready;
    logic [kmrb_pkg::CMD_W-1:0]      command;
    logic [kmrb_pkg::CODE_W-1:0]     scan_code;
    logic                            key_pressed;
    logic [kmrb_pkg::INDEX_W-1:0]    entry_index;
    logic [kmrb_pkg::CODE_W-1:0]     first_code;
    logic [kmrb_pkg::CODE_W-1:0]     second_code;
    logic [kmrb_pkg::COL_W-1:0]      first_column;
    logic [kmrb_pkg::ROWS_W-1:0]     first_rows;
    logic [kmrb_pkg::COL_W-1:0]      second_column;
    logic [kmrb_pkg::ROWS_W-1:0]     second_rows;

    modport source (
        output valid, command, scan_code, key_pressed, entry_index,
               first_code, second_code, first_column, first_rows,
               second_column, second_rows,
        input  ready
    );

    modport sink (
        input  valid, command, scan_code, key_pressed, entry_index,
               first_code, second_code, first_column, first_rows,
               second_column, second_rows,
        output ready
    );
endinterface

// ===== design/kmrb_out_if.sv =====
interface kmrb_out_if;
    logic                        valid;
    logic                        ready;
    logic [kmrb_pkg::COL_W-1:0]  column;
    logic [kmrb_pkg::ROWS_W-1:0] row_bits;
    logic                        last;

    modport source (
        output valid, column, row_bits, last,
        input  ready
    );

    modport sink (
        input  valid, column, row_bits, last,
        output ready
    );
endinterface

// ===== design/kmrb_ctrl.sv =====
module kmrb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [kmrb_pkg::CMD_W-1:0]    in_command,
    output logic                          in_ready,
    input  kmrb_pkg::ctrl_status_t        status,
    output kmrb_pkg::ctrl_cmd_t           cmd
);
    import kmrb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_command)
                        CMD_KEY_EVENT:   cmd.key_wr = 1'b1;
                        CMD_WRITE_ENTRY: cmd.tbl_wr = 1'b1;
                        CMD_BUILD:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.walk_en = 1'b1;
                if (status.walk_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_load = status.out_free;
                if (status.out_free && status.emit_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/kmrb_datapath.sv =====
module kmrb_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kmrb_pkg::in_item_t            item,
    input  kmrb_pkg::ctrl_cmd_t           cmd,
    output kmrb_pkg::ctrl_status_t        status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [kmrb_pkg::COL_W-1:0]    out_column,
    output logic [kmrb_pkg::ROWS_W-1:0]   out_row_bits,
    output logic                          out_last
);
    import kmrb_pkg::*;

    logic [KEY_CODES-1:0]     key_bits_reg;
    logic [TABLE_ENTRIES-1:0] entry_vld_reg;
    entry_t                   tbl_mem [TABLE_ENTRIES];

    logic [CNT_W-1:0]  issue_cnt_reg;
    logic              s1_valid_reg;
    entry_t            mem_rd_reg;
    logic              vld_rd_reg;
    entry_t            entry_s1;
    logic              s2_valid_reg;
    entry_t            entry_s2_reg;
    logic              key_a_reg;
    logic              key_b_reg;

    logic [ROWS_W-1:0] matrix_reg  [MATRIX_COLUMNS];
    logic [ROWS_W-1:0] matrix_next [MATRIX_COLUMNS];

    logic [COL_W-1:0]  emit_cnt_reg;
    logic              out_valid_reg;
    logic [COL_W-1:0]  column_reg;
    logic [ROWS_W-1:0] row_bits_reg;
    logic              last_reg;

    logic issue;
    logic s2_live;
    logic term;
    logic single;
    logic apply;
    logic stop_now;
    logic tbl_wr_ok;

    assign tbl_wr_ok = cmd.tbl_wr && (int'(item.entry_index) < TABLE_ENTRIES);
    assign issue     = cmd.walk_en && !stop_now &&
                       (issue_cnt_reg != CNT_W'(TABLE_ENTRIES));

    // entries never written read as zero
    assign entry_s1 = vld_rd_reg ? mem_rd_reg : '0;

    // evaluation stage
    assign s2_live  = cmd.walk_en && s2_valid_reg;
    assign term     = (entry_s2_reg.code_a == '0) && (entry_s2_reg.code_b == '0);
    assign single   = (entry_s2_reg.code_b == '0);
    assign apply    = s2_live && (entry_s2_reg.code_a != '0) &&
                      (single ? key_a_reg : (key_a_reg && key_b_reg));
    assign stop_now = s2_live && (term || (apply && !single));

    assign status.walk_done = cmd.walk_en && (stop_now ||
                              ((issue_cnt_reg == CNT_W'(TABLE_ENTRIES)) &&
                               !s1_valid_reg && !s2_valid_reg));
    assign status.emit_last = (emit_cnt_reg == COL_W'(MATRIX_COLUMNS - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int c = 0; c < MATRIX_COLUMNS; c++)
        begin
            matrix_next[c] = matrix_reg[c];
            if (apply && (entry_s2_reg.col_a == COL_W'(c)))
                matrix_next[c] = matrix_next[c] | entry_s2_reg.rows_a;
            if (apply && (entry_s2_reg.col_b == COL_W'(c)))
                matrix_next[c] = matrix_next[c] | entry_s2_reg.rows_b;
            if (cmd.start)
                matrix_next[c] = '0;
        end
    end

    // table storage, no reset on the array itself
    always_ff @(posedge clk)
    begin
        if (tbl_wr_ok)
            tbl_mem[IDX_W'(item.entry_index)] <= item.entry;
        mem_rd_reg <= tbl_mem[issue_cnt_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        entry_s2_reg <= entry_s1;
        key_a_reg    <= key_bits_reg[entry_s1.code_a];
        key_b_reg    <= key_bits_reg[entry_s1.code_b];
        vld_rd_reg   <= entry_vld_reg[issue_cnt_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bits_reg  <= '0;
            entry_vld_reg <= '0;
        end
        else
        begin
            if (cmd.key_wr)
                key_bits_reg[item.scan_code] <= item.key_pressed;
            if (tbl_wr_ok)
                entry_vld_reg[IDX_W'(item.entry_index)] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            emit_cnt_reg  <= '0;
            for (int c = 0; c < MATRIX_COLUMNS; c++)
                matrix_reg[c] <= '0;
        end
        else
        begin
            for (int c = 0; c < MATRIX_COLUMNS; c++)
                matrix_reg[c] <= matrix_next[c];
            if (cmd.start)
            begin
                issue_cnt_reg <= '0;
                s1_valid_reg  <= 1'b0;
                s2_valid_reg  <= 1'b0;
                emit_cnt_reg  <= '0;
            end
            else
            begin
                if (issue)
                    issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg && !stop_now;
                if (cmd.emit_load)
                    emit_cnt_reg <= emit_cnt_reg + COL_W'(1);
            end
        end
    end

    // output register decouples the sink from the emit sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            column_reg   <= emit_cnt_reg;
            row_bits_reg <= matrix_reg[emit_cnt_reg];
            last_reg     <= status.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_column   = column_reg;
    assign out_row_bits = row_bits_reg;
    assign out_last     = last_reg;

endmodule

// ===== design/keyboard_matrix_rollover_builder.sv =====
// channel   direction  contents
// request   in         command, scan_code, key_pressed, entry_index, entry fields
// result    out        column, row_bits, last (eight per build)
//
// key events and table writes are taken while idle and do not leave that state
// a build walks the table through a three-stage read pipeline (table read, key
// read, evaluate) until a terminating entry or an applied two-key entry
// reaches evaluate or the whole table is done, then emits the eight columns
// reset releases every key and clears the table valid bits at once
// a stalled result holds in the output register; the next request is taken
// once the eighth byte sits in that register
module keyboard_matrix_rollover_builder (
    input  logic       clk,
    input  logic       rst_n,
    kmrb_in_if.sink    request,
    kmrb_out_if.source result
);
    import kmrb_pkg::*;

    in_item_t     item;
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign item.command      = request.command;
    assign item.scan_code    = request.scan_code;
    assign item.key_pressed  = request.key_pressed;
    assign item.entry_index  = request.entry_index;
    assign item.entry.code_a = request.first_code;
    assign item.entry.code_b = request.second_code;
    assign item.entry.col_a  = request.first_column;
    assign item.entry.rows_a = request.first_rows;
    assign item.entry.col_b  = request.second_column;
    assign item.entry.rows_b = request.second_rows;

    kmrb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (request.valid),
        .in_command (request.command),
        .in_ready   (request.ready),
        .status     (status),
        .cmd        (cmd)
    );

    kmrb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .out_column   (result.column),
        .out_row_bits (result.row_bits),
        .out_last     (result.last)
    );

endmodule
